FILE: src/dsu_pkg.sv
// Shared constants, types and state codes for the disjoint-set engine.
`timescale 1ns / 1ps
package dsu_pkg;

    localparam int NUM_ELEMENTS = 1024;
    localparam int IDX_W        = 10;
    localparam int ADDR_W       = $clog2(NUM_ELEMENTS);
    localparam int SIZE_W       = $clog2(NUM_ELEMENTS + 1);

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SIZE_W-1:0] t_size;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_COMP,
        S_SZ_A,
        S_MERGE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic  p_we;
        t_addr p_waddr;
        t_addr p_wdata;
        t_addr p_raddr;
        logic  s_we;
        t_addr s_waddr;
        t_size s_wdata;
        t_addr s_raddr;
    } t_mem_req;

    typedef struct packed {
        t_addr p_rdata;
        t_size s_rdata;
    } t_mem_rsp;

    typedef struct packed {
        logic idle;
        logic done;
        logic connected;
    } t_ctrl_stat;

endpackage

FILE: src/dsu_store.sv
// Parent-link and set-size memories, one write and one registered read port each.
`timescale 1ns / 1ps
module dsu_store (
    input  logic              i_clk,
    input  dsu_pkg::t_mem_req i_req,
    output dsu_pkg::t_mem_rsp o_rsp
);
    import dsu_pkg::*;

    t_addr r_parent_mem [NUM_ELEMENTS];
    t_size r_size_mem   [NUM_ELEMENTS];
    t_addr r_p_rdata;
    t_size r_s_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.p_we) begin
            r_parent_mem[i_req.p_waddr] <= i_req.p_wdata;
        end
        r_p_rdata <= r_parent_mem[i_req.p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.s_we) begin
            r_size_mem[i_req.s_waddr] <= i_req.s_wdata;
        end
        r_s_rdata <= r_size_mem[i_req.s_raddr];
    end

    assign o_rsp.p_rdata = r_p_rdata;
    assign o_rsp.s_rdata = r_s_rdata;

endmodule

FILE: src/dsu_ctrl.sv
// Sequencer for clearing, root walks, path compression and union by size.
`timescale 1ns / 1ps
module dsu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  dsu_pkg::t_idx       i_first,
    input  dsu_pkg::t_idx       i_second,
    input  logic                i_out_free,
    input  dsu_pkg::t_mem_rsp   i_rsp,
    output dsu_pkg::t_mem_req   o_req,
    output dsu_pkg::t_ctrl_stat o_stat
);
    import dsu_pkg::*;

    t_state r_state, n_state;
    t_addr  r_clr_cnt, n_clr_cnt;
    t_addr  r_a, n_a;
    t_addr  r_b, n_b;
    logic   r_phase, n_phase;
    t_addr  r_node, n_node;
    t_addr  r_root, n_root;
    t_addr  r_root_a, n_root_a;
    t_size  r_size_a, n_size_a;
    logic   r_result, n_result;
    logic   w_in_range;

    assign w_in_range = (32'(i_first) < NUM_ELEMENTS) && (32'(i_second) < NUM_ELEMENTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_phase  <= n_phase;
        r_node   <= n_node;
        r_root   <= n_root;
        r_root_a <= n_root_a;
        r_size_a <= n_size_a;
        r_result <= n_result;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == ADDR_W'(NUM_ELEMENTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = w_in_range ? S_WALK : S_RESULT;
            end
            S_WALK: begin
                if (i_rsp.p_rdata == r_node) n_state = S_COMP;
            end
            S_COMP: begin
                if (r_node == r_root) begin
                    if (!r_phase) begin
                        n_state = S_WALK;
                    end else if (r_root_a == r_root) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SZ_A;
                    end
                end
            end
            S_SZ_A:   n_state = S_MERGE;
            S_MERGE:  n_state = S_RESULT;
            S_RESULT: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_clr_cnt = r_clr_cnt;
        n_a       = r_a;
        n_b       = r_b;
        n_phase   = r_phase;
        n_node    = r_node;
        n_root    = r_root;
        n_root_a  = r_root_a;
        n_size_a  = r_size_a;
        n_result  = r_result;
        o_req         = '0;
        o_req.p_raddr = r_node;
        o_req.s_raddr = r_root_a;
        o_stat.idle      = 1'b0;
        o_stat.done      = 1'b0;
        o_stat.connected = r_result;
        unique case (r_state)
            S_CLEAR: begin
                o_req.p_we    = 1'b1;
                o_req.p_waddr = r_clr_cnt;
                o_req.p_wdata = r_clr_cnt;
                o_req.s_we    = 1'b1;
                o_req.s_waddr = r_clr_cnt;
                o_req.s_wdata = SIZE_W'(1);
                n_clr_cnt     = r_clr_cnt + ADDR_W'(1);
            end
            S_IDLE: begin
                o_stat.idle   = 1'b1;
                o_req.p_raddr = ADDR_W'(i_first);
                if (i_start) begin
                    n_a      = ADDR_W'(i_first);
                    n_b      = ADDR_W'(i_second);
                    n_node   = ADDR_W'(i_first);
                    n_phase  = 1'b0;
                    n_result = 1'b0;
                end
            end
            S_WALK: begin
                if (i_rsp.p_rdata != r_node) begin
                    n_node        = i_rsp.p_rdata;
                    o_req.p_raddr = i_rsp.p_rdata;
                end else begin
                    n_root        = r_node;
                    n_node        = r_phase ? r_b : r_a;
                    o_req.p_raddr = r_phase ? r_b : r_a;
                end
            end
            S_COMP: begin
                if (r_node != r_root) begin
                    o_req.p_we    = 1'b1;
                    o_req.p_waddr = r_node;
                    o_req.p_wdata = r_root;
                    n_node        = i_rsp.p_rdata;
                    o_req.p_raddr = i_rsp.p_rdata;
                end else if (!r_phase) begin
                    n_root_a      = r_root;
                    n_phase       = 1'b1;
                    n_node        = r_b;
                    o_req.p_raddr = r_b;
                end else if (r_root_a == r_root) begin
                    n_result = 1'b1;
                end
            end
            S_SZ_A: begin
                n_size_a      = i_rsp.s_rdata;
                o_req.s_raddr = r_root;
            end
            S_MERGE: begin
                o_req.p_we    = 1'b1;
                o_req.s_we    = 1'b1;
                o_req.s_wdata = r_size_a + i_rsp.s_rdata;
                if (r_size_a > i_rsp.s_rdata) begin
                    o_req.p_waddr = r_root;
                    o_req.p_wdata = r_root_a;
                    o_req.s_waddr = r_root_a;
                end else begin
                    o_req.p_waddr = r_root_a;
                    o_req.p_wdata = r_root;
                    o_req.s_waddr = r_root;
                end
                n_result = 1'b0;
            end
            S_RESULT: begin
                o_stat.done = i_out_free;
            end
            default: begin
                o_stat.idle = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    ap_comp_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP && o_req.p_we) |-> (o_req.p_raddr != o_req.p_waddr))
        else $error("compression reads and writes the same parent entry");

    ap_merge_roots_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (o_req.p_waddr != o_req.s_waddr))
        else $error("merge attaches a root under itself");

    ap_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (32'(o_req.s_wdata) <= NUM_ELEMENTS))
        else $error("merged set size exceeds element count");

    ap_connected_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_result) |-> (r_root_a == r_root))
        else $error("connected result with different roots");
`endif

endmodule

FILE: src/disjoint_set_union_find_core.sv
// Top level of the disjoint-set engine: handshakes, output register, control and store.
// After reset a clearing pass sets every parent to itself and every size to 1;
// no item is taken until it ends.
// An item walks the links from each element to its root and compresses them, then reads
// both set sizes and merges the sets when the roots differ, all on one parent port.
// A new item can be taken from the cycle after the previous result moves to the output register.
`timescale 1ns / 1ps
module disjoint_set_union_find_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dsu_pkg::t_idx i_first_element,
    input  dsu_pkg::t_idx i_second_element,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_already_connected
);
    import dsu_pkg::*;

    t_mem_req   w_req;
    t_mem_rsp   w_rsp;
    t_ctrl_stat w_stat;
    logic       w_accept;
    logic       w_out_free;
    logic       r_out_valid;
    logic       r_connected;

    assign w_accept   = i_in_valid && w_stat.idle;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_stat.idle;

    dsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_first    (i_first_element),
        .i_second   (i_second_element),
        .i_out_free (w_out_free),
        .i_rsp      (w_rsp),
        .o_req      (w_req),
        .o_stat     (w_stat)
    );

    dsu_store u_store (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done) begin
            r_connected <= w_stat.connected;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_already_connected = r_connected;

endmodule
